// ===== rtl/core/rdmv_pkg.sv =====
// Shared types and constants for the rate-distortion motion vector select block.
package rdmv_pkg;

  // Vector component width and the run length limit.
  localparam int MV_WIDTH       = 12;
  localparam int MAX_CANDIDATES = 8;

  // Fixed field widths.
  localparam int SAD_W    = 16;
  localparam int WEIGHT_W = 10;
  localparam int IDX_W    = 3;
  localparam int COST_W   = 17;

  // Cost math widths: a magnitude plus one needs one bit more than a component.
  localparam int MAG_W  = MV_WIDTH + 1;
  localparam int PROD_W = 2 * MAG_W;
  localparam int BITS_W = $clog2(PROD_W);
  localparam int WB_W   = BITS_W + WEIGHT_W;
  localparam int SUM_W  = COST_W + 1;

  // Largest cost value; larger sums saturate here.
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // Stream payload widths, padded to whole bytes.
  localparam int S_FIELDS_W = 4 * MV_WIDTH + SAD_W;
  localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = 2 * MV_WIDTH + IDX_W + COST_W;
  localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  // Depth of the queue between the cost pipeline and the selector.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One costed candidate as it travels from the front to the back.
  typedef struct packed {
    logic signed [MV_WIDTH-1:0] x;
    logic signed [MV_WIDTH-1:0] y;
    logic [COST_W-1:0]          cost;
    logic                       last;
  } cand_t;

  // One selected winner.
  typedef struct packed {
    logic signed [MV_WIDTH-1:0] x;
    logic signed [MV_WIDTH-1:0] y;
    logic [IDX_W-1:0]           index;
    logic [COST_W-1:0]          cost;
  } result_t;

endpackage

// ===== rtl/core/rdmv_front.sv =====
// Cost pipeline: turns each input item into a candidate with its rate-distortion cost.
module rdmv_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [rdmv_pkg::MV_WIDTH-1:0] pred_x_i,
  input  logic signed [rdmv_pkg::MV_WIDTH-1:0] pred_y_i,
  input  logic signed [rdmv_pkg::MV_WIDTH-1:0] cand_x_i,
  input  logic signed [rdmv_pkg::MV_WIDTH-1:0] cand_y_i,
  input  logic [rdmv_pkg::SAD_W-1:0]       cand_sad_i,
  input  logic                             also_abs_i,
  input  logic                             last_i,
  input  logic [rdmv_pkg::WEIGHT_W-1:0]    rate_weight_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output rdmv_pkg::cand_t                  out_o
);
  import rdmv_pkg::*;

  // Index of the highest set bit; the argument is never zero here.
  function automatic logic [BITS_W-1:0] floor_log2(input logic [PROD_W-1:0] v);
    logic [BITS_W-1:0] r;
    r = '0;
    for (int i = 1; i < PROD_W; i++) begin
      if (v[i]) r = BITS_W'(i);
    end
    return r;
  endfunction

  // Magnitude of a signed value of MAG_W bits, one bit wider than a vector component.
  function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
    logic [MAG_W-1:0] r;
    r = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    return r;
  endfunction

  logic                       en;

  // Stage 1: magnitudes plus one.
  logic                       v1_q;
  logic [MAG_W-1:0]           pdx1_q, pdy1_q, adx1_q, ady1_q;
  logic signed [MV_WIDTH-1:0] x1_q, y1_q;
  logic [SAD_W-1:0]           sad1_q;
  logic                       abs1_q, last1_q;

  // Stage 2: products.
  logic                       v2_q;
  logic [PROD_W-1:0]          pprod2_q, aprod2_q;
  logic signed [MV_WIDTH-1:0] x2_q, y2_q;
  logic [SAD_W-1:0]           sad2_q;
  logic                       abs2_q, last2_q;

  // Stage 3: bit estimate.
  logic                       v3_q;
  logic [BITS_W-1:0]          bits3_q;
  logic signed [MV_WIDTH-1:0] x3_q, y3_q;
  logic [SAD_W-1:0]           sad3_q;
  logic                       last3_q;

  // Stage 4: final cost.
  logic                       v4_q;
  cand_t                      cand4_q;

  logic signed [MAG_W-1:0]    dx, dy;
  logic [BITS_W-1:0]          pbits, abits, bits_d;
  logic [WB_W-1:0]            wbits;
  logic [SUM_W-1:0]           sum;
  logic [COST_W-1:0]          cost_d;

  // The whole pipeline advances together unless the last stage is blocked.
  assign en         = !v4_q || out_ready_i;
  assign in_ready_o = en;

  assign dx = MAG_W'(cand_x_i) - MAG_W'(pred_x_i);
  assign dy = MAG_W'(cand_y_i) - MAG_W'(pred_y_i);

  // The absolute estimate only counts when it is flagged and smaller.
  always_comb begin
    pbits  = floor_log2(pprod2_q);
    abits  = floor_log2(aprod2_q);
    bits_d = (abs2_q && (abits < pbits)) ? abits : pbits;
  end

  // Weighted bits plus distortion, saturated to the cost width.
  always_comb begin
    wbits  = WB_W'(bits3_q) * WB_W'(rate_weight_i);
    sum    = SUM_W'(sad3_q) + SUM_W'(wbits);
    cost_d = sum[SUM_W-1] ? COST_MAX : sum[COST_W-1:0];
  end

  // Valid bits of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Payload of the stages.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pdx1_q  <= mag(dx) + MAG_W'(1);
      pdy1_q  <= mag(dy) + MAG_W'(1);
      adx1_q  <= mag(MAG_W'(cand_x_i)) + MAG_W'(1);
      ady1_q  <= mag(MAG_W'(cand_y_i)) + MAG_W'(1);
      x1_q    <= cand_x_i;
      y1_q    <= cand_y_i;
      sad1_q  <= cand_sad_i;
      abs1_q  <= also_abs_i;
      last1_q <= last_i;

      pprod2_q <= PROD_W'(pdx1_q) * PROD_W'(pdy1_q);
      aprod2_q <= PROD_W'(adx1_q) * PROD_W'(ady1_q);
      x2_q     <= x1_q;
      y2_q     <= y1_q;
      sad2_q   <= sad1_q;
      abs2_q   <= abs1_q;
      last2_q  <= last1_q;

      bits3_q <= bits_d;
      x3_q    <= x2_q;
      y3_q    <= y2_q;
      sad3_q  <= sad2_q;
      last3_q <= last2_q;

      cand4_q.x    <= x3_q;
      cand4_q.y    <= y3_q;
      cand4_q.cost <= cost_d;
      cand4_q.last <= last3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_o       = cand4_q;

endmodule

// ===== rtl/core/rdmv_queue.sv =====
// Short queue of costed candidates between the cost pipeline and the selector.
module rdmv_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  rdmv_pkg::cand_t push_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output rdmv_pkg::cand_t pop_o
);
  import rdmv_pkg::*;

  cand_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push && !pop) begin
        count_q <= count_q + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (QPTR_W+1)'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_i;
  end

endmodule

// ===== rtl/core/rdmv_back.sv =====
// Selector: running minimum over a run of candidates and the result register.
module rdmv_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rdmv_pkg::cand_t   in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rdmv_pkg::result_t out_o
);
  import rdmv_pkg::*;

  logic [COST_W-1:0]          best_cost_q, best_cost_d;
  logic signed [MV_WIDTH-1:0] best_x_q, best_x_d;
  logic signed [MV_WIDTH-1:0] best_y_q, best_y_d;
  logic [IDX_W-1:0]           best_idx_q, best_idx_d;
  logic [IDX_W-1:0]           cnt_q, pos;
  logic                       run_open_q;
  logic                       out_valid_q;
  result_t                    out_q;
  logic                       pop, take;

  // A last item needs the result register free or being emptied.
  assign in_ready_o = !in_i.last || !out_valid_q || out_ready_i;
  assign pop        = in_valid_i && in_ready_o;

  // First candidate of a run is taken outright; later ones must be strictly cheaper.
  always_comb begin
    pos         = run_open_q ? cnt_q : '0;
    take        = !run_open_q || (in_i.cost < best_cost_q);
    best_cost_d = take ? in_i.cost : best_cost_q;
    best_x_d    = take ? in_i.x    : best_x_q;
    best_y_d    = take ? in_i.y    : best_y_q;
    best_idx_d  = take ? pos       : best_idx_q;
  end

  // Run state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_cost_q <= '0;
      best_x_q    <= '0;
      best_y_q    <= '0;
      best_idx_q  <= '0;
      cnt_q       <= '0;
      run_open_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (pop) begin
        best_cost_q <= best_cost_d;
        best_x_q    <= best_x_d;
        best_y_q    <= best_y_d;
        best_idx_q  <= best_idx_d;
        if (in_i.last) begin
          run_open_q  <= 1'b0;
          cnt_q       <= '0;
          out_valid_q <= 1'b1;
        end else begin
          run_open_q <= 1'b1;
          // Positions past the run limit stick at the last one.
          cnt_q      <= (pos == IDX_W'(MAX_CANDIDATES - 1)) ? pos : pos + IDX_W'(1);
        end
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (pop && in_i.last) begin
      out_q.x     <= best_x_d;
      out_q.y     <= best_y_d;
      out_q.index <= best_idx_d;
      out_q.cost  <= best_cost_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A non-last item leaves the run open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !in_i.last |=> run_open_q)
    else $error("run not open after a non-last item");

  // The position counter never passes the run limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= IDX_W'(MAX_CANDIDATES - 1))
    else $error("candidate position past the run limit");

  // The winner of an open run never sits past the current position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_open_q |-> (best_idx_q <= cnt_q))
    else $error("best index ahead of the position counter");

  // A held result is never overwritten before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !(pop && in_i.last))
    else $error("result overwritten while stalled");

endmodule

// ===== rtl/core/rd_cost_motion_vector_select_top.sv =====
// Top level of the rate-distortion motion vector select block.
//
// Usage: each macroblock sends a run of candidate items on the slave stream.
// Every item carries the predictor, the candidate vector and its SAD; tuser
// bit 0 asks for the smaller of predicted and absolute bit estimates, and
// tlast marks the last candidate of the run. On that last candidate one
// result item leaves on the master stream with the cheapest vector, its
// position in the run and its cost; earlier items give no result.
// The cfg channel writes rate_weight (always ready); write it only while
// no run is in flight.
// A result passes the four cost pipeline stages, the queue and the selector's
// result register after its last candidate is accepted.
// Throughput: one candidate per cycle unless the master stalls; the cost math
// is a four-stage pipeline and the selector compares one candidate per cycle.
// Stall: a stalled master holds its result while the selector keeps taking
// non-last candidates; the next last candidate waits, the four-entry queue
// fills, then the cost pipeline stalls and s_axis_tready drops with it.
// Reset: clears the run state, empties the pipeline and queue, and sets
// rate_weight to 4.
module rd_cost_motion_vector_select_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input items.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // Fields from bit 0: pred_x, pred_y, cand_x, cand_y, cand_sad.
  input  logic [rdmv_pkg::S_DATA_W-1:0] s_axis_tdata_i,
  // Fields from bit 0: also_absolute_bits.
  input  logic                          s_axis_tuser_i,
  // last_candidate.
  input  logic                          s_axis_tlast_i,
  // Result items.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // Fields from bit 0: best_x, best_y, best_index, best_cost, zero padding.
  output logic [rdmv_pkg::M_DATA_W-1:0] m_axis_tdata_o,
  // Configuration write of rate_weight.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rdmv_pkg::WEIGHT_W-1:0] cfg_data_i
);
  import rdmv_pkg::*;

  logic [WEIGHT_W-1:0] rate_weight_q;
  logic                f_valid, f_ready;
  cand_t               f_cand;
  logic                q_valid, q_ready;
  cand_t               q_cand;
  result_t             res;

  // Configuration register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_weight_q <= WEIGHT_W'(4);
    end else if (cfg_valid_i) begin
      rate_weight_q <= cfg_data_i;
    end
  end

  rdmv_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .pred_x_i      (s_axis_tdata_i[MV_WIDTH-1:0]),
    .pred_y_i      (s_axis_tdata_i[2*MV_WIDTH-1:MV_WIDTH]),
    .cand_x_i      (s_axis_tdata_i[3*MV_WIDTH-1:2*MV_WIDTH]),
    .cand_y_i      (s_axis_tdata_i[4*MV_WIDTH-1:3*MV_WIDTH]),
    .cand_sad_i    (s_axis_tdata_i[4*MV_WIDTH+SAD_W-1:4*MV_WIDTH]),
    .also_abs_i    (s_axis_tuser_i),
    .last_i        (s_axis_tlast_i),
    .rate_weight_i (rate_weight_q),
    .out_valid_o   (f_valid),
    .out_ready_i   (f_ready),
    .out_o         (f_cand)
  );

  rdmv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_i       (f_cand),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_o        (q_cand)
  );

  rdmv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_i        (q_cand),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  // Pack the result, first field in the lowest bits.
  assign m_axis_tdata_o = M_DATA_W'({res.cost, res.index, res.y, res.x});

endmodule
